// File: rtl/wpkm_pkg.sv
// shared types and constants of the word prefix keyword matcher
`default_nettype none

package wpkm_pkg;

   // configuration register indexes
   localparam int CSR_INDEX_W = 4;
   localparam logic [CSR_INDEX_W-1:0] CSR_KEY_LOW    = 4'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_KEY_HIGH   = 4'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_KEY_LENGTH = 4'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_QUERY      = 4'd3;

   localparam int CSR_DATA_W = 64;
   localparam int KEY_SLOTS  = 16;
   localparam int LEN_W      = 5;

   // byte codes with a meaning to the parser
   localparam logic [7:0] CH_NUL    = 8'h00;
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_DQUOTE = 8'h22;
   localparam logic [7:0] CH_SQUOTE = 8'h27;
   localparam logic [7:0] CH_UPPER_A = 8'h41;
   localparam logic [7:0] CH_UPPER_Z = 8'h5A;
   localparam logic [7:0] CASE_OFFSET = 8'h20;

   // keyword configuration seen by the parser
   typedef struct packed {
      logic [KEY_SLOTS-1:0][7:0] key;
      logic [LEN_W-1:0]          key_len;
      logic                      query_present;
   } key_cfg_type;

endpackage

`default_nettype wire

// File: rtl/word_prefix_keyword_matcher_core.sv
// top level of the word prefix keyword matcher
`default_nettype none

// Takes a name list one byte per transaction, ended by a zero byte, splits it
// into whitespace separated or quoted words, lowercases them and reports at
// the zero byte whether any word starts with the configured keyword. One byte
// is taken every cycle, but a stalled result holds off input only while the
// result register is full and not being taken. The parser state is a mode, a
// word position and a few flags, updated by one short compare per byte. The
// found bit is registered in the cycle after the end byte is taken.
// Registers: 0 keyword chars 0-7, 1 keyword chars 8-15, 2 keyword length,
// 3 query present; writes are always taken, unknown indexes are dropped.
module word_prefix_keyword_matcher_core #(
   parameter int KEY_CHARS = 16
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output logic                                    req_ready,
   input  wire logic [7:0]                         req_ch,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_ready,
   output logic                                    rsp_found,
   input  wire logic                               csr_valid,
   output logic                                    csr_ready,
   input  wire logic [wpkm_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  wire logic [wpkm_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   wpkm_pkg::key_cfg_type cfg;
   logic                  req_fire;
   logic                  hit;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_found_ff, rsp_found_in;

   assign csr_ready = 1'b1;

   wpkm_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (csr_valid && csr_ready),
      .wr_index (csr_index),
      .wr_data  (csr_wdata),
      .cfg      (cfg)
   );

   // input is taken whenever the result register is free or draining
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_fire  = req_valid && req_ready;

   wpkm_scan #(
      .KEY_CHARS (KEY_CHARS)
   ) u_scan (
      .clock     (clock),
      .reset     (reset),
      .byte_fire (req_fire),
      .ch        (req_ch),
      .cfg       (cfg),
      .hit       (hit)
   );

   // result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_found_in = rsp_found_ff;
      if (req_fire && req_ch == wpkm_pkg::CH_NUL) begin
         rsp_valid_in = 1'b1;
         rsp_found_in = hit;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_found_ff <= rsp_found_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_found = rsp_found_ff;

`ifndef SYNTHESIS
   // every end byte yields a result in the next cycle
   a_end_gives_result: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_ch == wpkm_pkg::CH_NUL) |=> rsp_valid_ff)
      else $error("no result after end byte");

   // list bytes never produce a result on their own
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      (!rsp_valid_ff && !(req_fire && req_ch == wpkm_pkg::CH_NUL)) |=> !rsp_valid_ff)
      else $error("result without end byte");

   // input back pressure only while a held result blocks the register
   a_ready_rule: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (rsp_valid_ff && !rsp_ready))
      else $error("input stalled with free result register");
`endif

endmodule

`default_nettype wire

// File: rtl/wpkm_csr.sv
// configuration registers of the keyword matcher
`default_nettype none

module wpkm_csr (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                wr_en,
   input  wire logic [wpkm_pkg::CSR_INDEX_W-1:0]    wr_index,
   input  wire logic [wpkm_pkg::CSR_DATA_W-1:0]     wr_data,
   output wpkm_pkg::key_cfg_type                    cfg
);

   logic [wpkm_pkg::CSR_DATA_W-1:0] key_low_ff;
   logic [wpkm_pkg::CSR_DATA_W-1:0] key_high_ff;
   logic [wpkm_pkg::LEN_W-1:0]      key_len_ff;
   logic                            query_ff;

   // register writes, unknown indexes are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         key_low_ff  <= '0;
         key_high_ff <= '0;
         key_len_ff  <= '0;
         query_ff    <= 1'b0;
      end else if (wr_en) begin
         case (wr_index)
            wpkm_pkg::CSR_KEY_LOW:    key_low_ff  <= wr_data;
            wpkm_pkg::CSR_KEY_HIGH:   key_high_ff <= wr_data;
            wpkm_pkg::CSR_KEY_LENGTH: key_len_ff  <= wr_data[wpkm_pkg::LEN_W-1:0];
            wpkm_pkg::CSR_QUERY:      query_ff    <= wr_data[0];
            default: ;
         endcase
      end
   end

   // character 0 sits in the low byte of the low word
   assign cfg.key           = {key_high_ff, key_low_ff};
   assign cfg.key_len       = key_len_ff;
   assign cfg.query_present = query_ff;

endmodule

`default_nettype wire

// File: rtl/wpkm_scan.sv
// byte parser: word splitting, lowercasing and keyword prefix compare
`default_nettype none

module wpkm_scan #(
   parameter int KEY_CHARS = 16
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  byte_fire,
   input  wire logic [7:0]            ch,
   input  wire wpkm_pkg::key_cfg_type cfg,
   output logic                       hit
);

   localparam logic [wpkm_pkg::LEN_W-1:0] KEY_LEN_MAX = wpkm_pkg::LEN_W'(KEY_CHARS);

   typedef enum logic [1:0] {
      MODE_SKIP,
      MODE_WORD,
      MODE_SQUOTE,
      MODE_DQUOTE
   } mode_type;

   mode_type                   mode_ff, mode_in;
   logic [wpkm_pkg::LEN_W-1:0] idx_ff, idx_in;
   logic                       ok_ff, ok_in;
   logic                       found_ff, found_in;
   logic                       nonempty_ff;

   logic                       is_ws;
   logic [7:0]                 low_ch;
   logic [wpkm_pkg::LEN_W-1:0] klen;
   logic                       start_word;
   logic                       take_char;
   logic [wpkm_pkg::LEN_W-1:0] base_idx;
   logic                       base_ok;
   logic [wpkm_pkg::LEN_W-1:0] step_idx;
   logic                       step_ok;
   logic                       compare;

   // byte classes
   always_comb begin
      is_ws  = (ch == wpkm_pkg::CH_SPACE) || (ch inside {[wpkm_pkg::CH_TAB:wpkm_pkg::CH_CR]});
      low_ch = (ch inside {[wpkm_pkg::CH_UPPER_A:wpkm_pkg::CH_UPPER_Z]}) ?
               ch + wpkm_pkg::CASE_OFFSET : ch;
      klen   = (cfg.key_len > KEY_LEN_MAX) ? KEY_LEN_MAX : cfg.key_len;
   end

   // mode transitions
   always_comb begin
      mode_in    = mode_ff;
      start_word = 1'b0;
      take_char  = 1'b0;
      case (mode_ff)
         MODE_SKIP: begin
            if (!is_ws) begin
               start_word = 1'b1;
               if (ch == wpkm_pkg::CH_SQUOTE) begin
                  mode_in = MODE_SQUOTE;
               end else if (ch == wpkm_pkg::CH_DQUOTE) begin
                  mode_in = MODE_DQUOTE;
               end else begin
                  mode_in   = MODE_WORD;
                  take_char = 1'b1;
               end
            end
         end
         MODE_WORD: begin
            if (is_ws) mode_in = MODE_SKIP;
            else       take_char = 1'b1;
         end
         MODE_SQUOTE: begin
            if (ch == wpkm_pkg::CH_SQUOTE) mode_in = MODE_SKIP;
            else                           take_char = 1'b1;
         end
         MODE_DQUOTE: begin
            if (ch == wpkm_pkg::CH_DQUOTE) mode_in = MODE_SKIP;
            else                           take_char = 1'b1;
         end
         default: mode_in = MODE_SKIP;
      endcase
   end

   // compare one character against the keyword slot at the word position
   always_comb begin
      base_idx = start_word ? '0 : idx_ff;
      base_ok  = start_word ? 1'b1 : ok_ff;
      compare  = take_char && (base_idx < klen);
      step_idx = base_idx + wpkm_pkg::LEN_W'(1);
      step_ok  = base_ok && (low_ch == cfg.key[base_idx[wpkm_pkg::LEN_W-2:0]]);
      idx_in   = compare ? step_idx : base_idx;
      ok_in    = compare ? step_ok : base_ok;
      found_in = found_ff || (compare && step_ok && (step_idx == klen));
   end

   // end of list verdict
   assign hit = cfg.query_present && nonempty_ff && ((klen == '0) || found_ff);

   // parser state, cleared by reset and by the end byte
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff     <= MODE_SKIP;
         idx_ff      <= '0;
         ok_ff       <= 1'b1;
         found_ff    <= 1'b0;
         nonempty_ff <= 1'b0;
      end else if (byte_fire) begin
         if (ch == wpkm_pkg::CH_NUL) begin
            mode_ff     <= MODE_SKIP;
            idx_ff      <= '0;
            ok_ff       <= 1'b1;
            found_ff    <= 1'b0;
            nonempty_ff <= 1'b0;
         end else begin
            mode_ff     <= mode_in;
            idx_ff      <= idx_in;
            ok_ff       <= ok_in;
            found_ff    <= found_in;
            nonempty_ff <= 1'b1;
         end
      end
   end

`ifndef SYNTHESIS
   // the end byte returns the parser to its starting state
   a_end_clears: assert property (@(posedge clock) disable iff (reset)
      (byte_fire && ch == wpkm_pkg::CH_NUL) |=>
         (mode_ff == MODE_SKIP && idx_ff == '0 && ok_ff && !found_ff && !nonempty_ff))
      else $error("parser state not cleared after end byte");

   // a match needs at least one byte of the list
   a_found_nonempty: assert property (@(posedge clock) disable iff (reset)
      found_ff |-> nonempty_ff)
      else $error("match flagged on an empty list");

   // a word position only advances inside a non-empty list
   a_idx_nonempty: assert property (@(posedge clock) disable iff (reset)
      (idx_ff != '0) |-> nonempty_ff)
      else $error("word position set with no list bytes");
`endif

endmodule

`default_nettype wire

// File: tb/tb_top.sv
// testbench of the word prefix keyword matcher: directed and random name lists
`timescale 1ns / 1ps

module tb_top;

   localparam int HOLD_CYCLES   = 300;
   localparam int CYCLE_LIMIT   = 200000;
   localparam int SETTLE_CYCLES = 4;

   typedef enum logic [1:0] {SKIP_WS, IN_WORD, IN_SQUOTE, IN_DQUOTE} scan_mode_type;

   logic                             clock = 1'b0;
   logic                             reset;
   logic                             req_valid;
   logic                             req_ready;
   logic [7:0]                       req_ch;
   logic                             rsp_valid;
   logic                             rsp_ready = 1'b0;
   logic                             rsp_found;
   logic                             csr_valid;
   logic                             csr_ready;
   logic [wpkm_pkg::CSR_INDEX_W-1:0] csr_index;
   logic [wpkm_pkg::CSR_DATA_W-1:0]  csr_wdata;

   // keyword copy and list scanner state
   wpkm_pkg::key_cfg_type      key_cfg       = '0;
   scan_mode_type              scan_mode     = SKIP_WS;
   logic [wpkm_pkg::LEN_W-1:0] word_pos      = '0;
   logic                       word_agrees   = 1'b1;
   logic                       list_hit      = 1'b0;
   logic                       list_nonempty = 1'b0;

   logic expected_found[$];
   logic want_found;
   logic [7:0] list_bytes[$];

   int errors        = 0;
   int cycle_count   = 0;
   int sent_bytes    = 0;
   int send_idle_pct = 0;
   int rsp_stall_pct = 0;
   logic rsp_hold    = 1'b0;
   event hold_start;

   word_prefix_keyword_matcher_core #(
      .KEY_CHARS(wpkm_pkg::KEY_SLOTS)
   ) u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_ch    (req_ch),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_found (rsp_found),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // 8 ns clock
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t ns: timed out with %0d results pending", $time, expected_found.size());
         $display("simulation failed");
         $finish;
      end
   end

   // result side: random stalls, forced low during a hold-off
   always @(posedge clock) begin
      if (rsp_hold)
         rsp_ready <= 1'b0;
      else
         rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   // long hold-off of the result side
   initial begin
      forever begin
         @(hold_start);
         rsp_hold <= 1'b1;
         repeat (HOLD_CYCLES) @(posedge clock);
         rsp_hold <= 1'b0;
      end
   end

   // compare each result transaction with the oldest expected found bit
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_found.size() == 0) begin
            $display("%0t ns: unexpected result, expected none actual found=%0b",
                     $time, rsp_found);
            errors++;
         end else begin
            want_found = expected_found.pop_front();
            if (rsp_found !== want_found) begin
               $display("%0t ns: found mismatch, expected %0b actual %0b",
                        $time, want_found, rsp_found);
               errors++;
            end
         end
      end
   end

   function automatic logic [wpkm_pkg::LEN_W-1:0] effective_len();
      return (key_cfg.key_len > wpkm_pkg::KEY_SLOTS) ?
             wpkm_pkg::LEN_W'(wpkm_pkg::KEY_SLOTS) : key_cfg.key_len;
   endfunction

   function automatic logic is_space(input logic [7:0] c);
      return c == wpkm_pkg::CH_SPACE || (c >= wpkm_pkg::CH_TAB && c <= wpkm_pkg::CH_CR);
   endfunction

   function automatic logic [7:0] to_lower(input logic [7:0] c);
      return (c >= wpkm_pkg::CH_UPPER_A && c <= wpkm_pkg::CH_UPPER_Z) ?
             c + wpkm_pkg::CASE_OFFSET : c;
   endfunction

   function automatic logic [7:0] lower_letter();
      return wpkm_pkg::CH_UPPER_A + wpkm_pkg::CASE_OFFSET + 8'($urandom_range(25));
   endfunction

   function automatic logic [7:0] space_byte();
      return ($urandom_range(3) == 0) ? wpkm_pkg::CH_SPACE :
             8'($urandom_range(wpkm_pkg::CH_CR, wpkm_pkg::CH_TAB));
   endfunction

   // mostly letters, some spaces, some arbitrary non-zero bytes
   function automatic logic [7:0] body_byte();
      int r;
      r = $urandom_range(9);
      if (r < 4) return lower_letter();
      if (r < 6) return wpkm_pkg::CH_UPPER_A + 8'($urandom_range(25));
      if (r == 6) return wpkm_pkg::CH_SPACE;
      return 8'($urandom_range(255, 1));
   endfunction

   task automatic open_word(input scan_mode_type next_mode);
      scan_mode   = next_mode;
      word_pos    = '0;
      word_agrees = 1'b1;
   endtask

   // compare one word character against the keyword, up to its length
   task automatic match_char(input logic [7:0] c);
      if (word_pos < effective_len()) begin
         if (to_lower(c) != key_cfg.key[word_pos]) word_agrees = 1'b0;
         word_pos++;
         if (word_pos == effective_len() && word_agrees) list_hit = 1'b1;
      end
   endtask

   // advance the list scanner by one accepted byte
   task automatic scan_byte(input logic [7:0] c);
      if (c == wpkm_pkg::CH_NUL) begin
         expected_found.push_back(key_cfg.query_present && list_nonempty &&
                                  (effective_len() == 0 || list_hit));
         scan_mode     = SKIP_WS;
         word_pos      = '0;
         word_agrees   = 1'b1;
         list_hit      = 1'b0;
         list_nonempty = 1'b0;
      end else begin
         list_nonempty = 1'b1;
         case (scan_mode)
            SKIP_WS: begin
               if (c == wpkm_pkg::CH_SQUOTE)
                  open_word(IN_SQUOTE);
               else if (c == wpkm_pkg::CH_DQUOTE)
                  open_word(IN_DQUOTE);
               else if (!is_space(c)) begin
                  open_word(IN_WORD);
                  match_char(c);
               end
            end
            IN_WORD: begin
               if (is_space(c)) scan_mode = SKIP_WS;
               else match_char(c);
            end
            IN_SQUOTE: begin
               if (c == wpkm_pkg::CH_SQUOTE) scan_mode = SKIP_WS;
               else match_char(c);
            end
            default: begin
               if (c == wpkm_pkg::CH_DQUOTE) scan_mode = SKIP_WS;
               else match_char(c);
            end
         endcase
      end
   endtask

   // one byte transaction, with random idle cycles ahead of it
   task automatic send_byte(input logic [7:0] c);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_ch    <= c;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      scan_byte(c);
      sent_bytes++;
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) send_byte(s[i]);
      send_byte(wpkm_pkg::CH_NUL);
   endtask

   // stop offering bytes and let every pending result come out
   task automatic wait_all_found();
      req_valid <= 1'b0;
      while (expected_found.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [wpkm_pkg::CSR_INDEX_W-1:0] idx,
                            input logic [wpkm_pkg::CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         wpkm_pkg::CSR_KEY_LOW:    key_cfg.key[7:0]      = data;
         wpkm_pkg::CSR_KEY_HIGH:   key_cfg.key[15:8]     = data;
         wpkm_pkg::CSR_KEY_LENGTH: key_cfg.key_len       = data[wpkm_pkg::LEN_W-1:0];
         wpkm_pkg::CSR_QUERY:      key_cfg.query_present = data[0];
         default: ;
      endcase
   endtask

   // reprogram the keyword once the block is idle, optionally with a stray index
   task automatic load_keyword(input logic [wpkm_pkg::CSR_DATA_W-1:0] lo, hi,
                               len_data, query_data,
                               input bit stray);
      wait_all_found();
      write_csr(wpkm_pkg::CSR_KEY_LOW, lo);
      write_csr(wpkm_pkg::CSR_KEY_HIGH, hi);
      write_csr(wpkm_pkg::CSR_KEY_LENGTH, len_data);
      write_csr(wpkm_pkg::CSR_QUERY, query_data);
      if (stray)
         write_csr(wpkm_pkg::CSR_INDEX_W'($urandom_range(2**wpkm_pkg::CSR_INDEX_W - 1,
                                                         wpkm_pkg::CSR_QUERY + 1)),
                   {$urandom, $urandom});
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic random_keyword();
      logic [wpkm_pkg::KEY_SLOTS-1:0][7:0] chars;
      logic [wpkm_pkg::CSR_DATA_W-1:0] len_data;
      logic [wpkm_pkg::CSR_DATA_W-1:0] query_data;
      int pick;
      int klen;
      pick = $urandom_range(19);
      if (pick == 0) klen = 0;
      else if (pick == 1) klen = $urandom_range(31, wpkm_pkg::KEY_SLOTS + 1);
      else if (pick == 2) klen = wpkm_pkg::KEY_SLOTS;
      else klen = $urandom_range(6, 1);
      pick = $urandom_range(9);
      if (pick == 0) chars = '0;
      else if (pick == 1) chars = '1;
      else if (pick < 4) chars = {$urandom, $urandom, $urandom, $urandom};
      else
         for (int i = 0; i < wpkm_pkg::KEY_SLOTS; i++)
            chars[i] = (i < klen) ? lower_letter() : 8'($urandom_range(255));
      // upper data bits are don't-care, so sometimes fill them
      if ($urandom_range(3) == 0) len_data = {$urandom, $urandom};
      else len_data = '0;
      len_data[wpkm_pkg::LEN_W-1:0] = klen[wpkm_pkg::LEN_W-1:0];
      if ($urandom_range(3) == 0) query_data = {$urandom, $urandom};
      else query_data = '0;
      query_data[0] = ($urandom_range(9) != 0);
      load_keyword(chars[7:0], chars[15:8], len_data, query_data, $urandom_range(4) == 0);
   endtask

   // one word into list_bytes: keyword prefix, near miss or random, maybe quoted
   task automatic append_word(input bit open_ended, output bit quoted);
      logic [7:0] closer;
      logic [7:0] c;
      int shape;
      int plen;
      shape  = $urandom_range(4);
      quoted = open_ended || shape < 2;
      closer = $urandom_range(1) ? wpkm_pkg::CH_SQUOTE : wpkm_pkg::CH_DQUOTE;
      if (quoted) list_bytes.push_back(closer);
      shape = $urandom_range(3);
      plen  = (shape < 2) ? effective_len() : 0;
      for (int j = 0; j < plen; j++) begin
         c = key_cfg.key[j];
         if (c >= wpkm_pkg::CH_UPPER_A + wpkm_pkg::CASE_OFFSET &&
             c <= wpkm_pkg::CH_UPPER_Z + wpkm_pkg::CASE_OFFSET &&
             $urandom_range(1))
            c = c - wpkm_pkg::CASE_OFFSET;
         if (c == wpkm_pkg::CH_NUL) c = lower_letter();
         list_bytes.push_back(c);
      end
      if (shape == 1 && plen > 0)
         list_bytes[list_bytes.size() - 1 - $urandom_range(plen - 1)] = body_byte();
      repeat ($urandom_range(6)) list_bytes.push_back(body_byte());
      if (quoted && !open_ended) list_bytes.push_back(closer);
   endtask

   // one list: mostly well formed words, some noise and unterminated quotes
   task automatic send_random_list();
      int kind;
      int nwords;
      bit was_quoted;
      list_bytes.delete();
      was_quoted = 1'b0;
      kind = $urandom_range(99);
      if (kind < 8) begin
         repeat ($urandom_range(20)) list_bytes.push_back(8'($urandom_range(255, 1)));
      end else begin
         nwords = $urandom_range(5);
         if (nwords == 0) repeat ($urandom_range(3)) list_bytes.push_back(space_byte());
         for (int w = 0; w < nwords; w++) begin
            // a word may directly follow a closing quote
            if (!(was_quoted && $urandom_range(2) == 0) && (w > 0 || $urandom_range(1) == 0))
               repeat ($urandom_range(3, 1)) list_bytes.push_back(space_byte());
            append_word(kind < 14 && w == nwords - 1, was_quoted);
         end
      end
      foreach (list_bytes[i]) send_byte(list_bytes[i]);
      send_byte(wpkm_pkg::CH_NUL);
   endtask

   // hand-picked lists around each special case
   task automatic test_directed_lists();
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      // keyword "ab"
      load_keyword(64'h6261, '0, 2, 1, 1'b1);
      send_text("");
      send_text("x\"y\"Ab");
      send_text("a'b");
      send_byte(8'hFF);
      send_byte(wpkm_pkg::CH_CR);
      send_text("ABx");
      // absent query
      load_keyword(64'h6261, '0, 2, 0, 1'b0);
      send_text("ab");
      // empty keyword on a whitespace-only list
      load_keyword(64'h6261, '0, 0, 1, 1'b0);
      send_text("\t");
      // length beyond the keyword slots saturates
      load_keyword(64'h6161616161616161, 64'h6161616161616161, 31, 1, 1'b0);
      send_text("AAAAAAAAAAAAAAAAz");
      // zero keyword byte inside the length
      load_keyword(64'h61, '0, 2, 1, 1'b0);
      send_text("a b");
   endtask

   task automatic test_random_lists(input int idle_pct, input int stall_pct, input int n);
      int start;
      send_idle_pct = idle_pct;
      rsp_stall_pct = stall_pct;
      start = sent_bytes;
      random_keyword();
      while (sent_bytes - start < n) begin
         if ($urandom_range(7) == 0) random_keyword();
         send_random_list();
      end
      wait_all_found();
   endtask

   // result side held off while short lists keep coming, so the input stalls
   task automatic test_result_backpressure();
      load_keyword(64'h6261, '0, 2, 1, 1'b0);
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      -> hold_start;
      repeat (30) send_text("aB");
      wait_all_found();
   endtask

   initial begin
      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_ch    <= wpkm_pkg::CH_NUL;
      csr_valid <= 1'b0;
      csr_index <= wpkm_pkg::CSR_KEY_LOW;
      csr_wdata <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      test_directed_lists();
      test_random_lists(0, 0, 390);
      test_random_lists(48, 0, 390);
      test_random_lists(0, 48, 390);
      test_random_lists(25, 25, 390);
      test_result_backpressure();

      wait_all_found();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (errors == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
